[design/v2wc_pkg.sv]
// ----------------------------------------------------------------------------
// v2wc_pkg: shared types and constants for the window correlation block
// Holds the register indexes and the front-to-back position tag type.
// ----------------------------------------------------------------------------
package v2wc_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW0   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW1   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW2   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW3   = 3'd5;

    localparam int COEF_BITS = 16;
    localparam int ROW_BITS  = 16;
    localparam int COL_BITS  = 10;
    localparam int SUM_BITS  = 36;

    // Position tag that travels with each window from front to back
    typedef struct packed {
        logic                emit;
        logic                last;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } v2wc_tag_t;

endpackage

[design/v2wc_front.sv]
// ----------------------------------------------------------------------------
// v2wc_front: sample intake, line store and window register
// Tracks raster position, keeps K-1 rows in memory, and emits window + tag.
// ----------------------------------------------------------------------------
module v2wc_front
    import v2wc_pkg::*;
#(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_valid,
    input  logic [15:0]                                in_sample,
    input  logic                                       advance,
    input  logic [10:0]                                width,
    input  logic [15:0]                                height,
    output logic                                       win_valid,
    output logic signed [SAMPLE_BITS-1:0]              win_reg [KERNEL_SIZE][KERNEL_SIZE],
    output v2wc_tag_t                                  tag
);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LR  = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
    localparam int CW  = 13;

    // Stage 1: position, memory read
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [CW-1:0]       w_eff;
    logic [16:0]         h_eff;
    logic                row_end, frame_end, in_mem;
    logic signed [SAMPLE_BITS-1:0] s_val;

    // Line store rows, one memory each
    logic signed [SAMPLE_BITS-1:0] lmem [LR][MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] rd_reg [LR];

    // Stage 1 pipeline registers
    logic                          p_valid_reg;
    logic signed [SAMPLE_BITS-1:0] p_s_reg;
    logic                          p_inmem_reg;
    logic [AW-1:0]                 p_addr_reg;
    v2wc_tag_t                     p_tag_reg;

    logic                          w_valid_reg;
    v2wc_tag_t                     tag_reg;
    logic signed [SAMPLE_BITS-1:0] col_vec [KERNEL_SIZE];

    assign s_val = signed'(in_sample[SAMPLE_BITS-1:0]);

    // Clamp geometry
    always_comb begin
        if (width == 11'd0) begin
            w_eff = CW'(1);
        end else if (CW'(width) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(width);
        end
        h_eff     = (height == 16'd0) ? 17'd1 : {1'b0, height};
        row_end   = col_reg >= w_eff - CW'(1);
        frame_end = row_end && ({1'b0, row_reg} >= h_eff - 17'd1);
        in_mem    = col_reg < CW'(MAX_WIDTH);
        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + ROW_BITS'(1);
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    // Advance raster position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            p_valid_reg <= 1'b0;
        end else if (advance) begin
            p_valid_reg <= in_valid;
            if (in_valid) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Capture sample and tag for stage 2
    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            p_s_reg        <= s_val;
            p_inmem_reg    <= in_mem;
            p_addr_reg     <= col_reg[AW-1:0];
            p_tag_reg.emit <= (row_reg >= ROW_BITS'(KERNEL_SIZE - 1)) &&
                              (col_reg >= CW'(KERNEL_SIZE - 1));
            p_tag_reg.last <= frame_end;
            p_tag_reg.row  <= row_reg - ROW_BITS'(KERNEL_SIZE - 1);
            p_tag_reg.col  <= COL_BITS'(col_reg - CW'(KERNEL_SIZE - 1));
        end
    end

    // Line store: read at stage 1, shift rows up at stage 2
    for (genvar r = 0; r < LR; r++) begin : g_line
        always_ff @(posedge aclk) begin
            if (advance && in_valid && in_mem) begin
                rd_reg[r] <= lmem[r][col_reg[AW-1:0]];
            end
            if (advance && p_valid_reg && p_inmem_reg && KERNEL_SIZE > 1) begin
                if (r == LR - 1) begin
                    lmem[r][p_addr_reg] <= p_s_reg;
                end else begin
                    lmem[r][p_addr_reg] <= rd_reg[(r + 1) % LR];
                end
            end
        end
    end

    // Build new window column
    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            if (r == KERNEL_SIZE - 1) begin
                col_vec[r] = p_s_reg;
            end else begin
                col_vec[r] = p_inmem_reg ? rd_reg[r % LR] : '0;
            end
        end
    end

    // Shift window and register tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (advance) begin
            w_valid_reg <= p_valid_reg && p_tag_reg.emit;
            if (p_valid_reg) begin
                for (int r = 0; r < KERNEL_SIZE; r++) begin
                    for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
                        win_reg[r][c] <= win_reg[r][c + 1];
                    end
                    win_reg[r][KERNEL_SIZE - 1] <= col_vec[r];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p_valid_reg) begin
            tag_reg <= p_tag_reg;
        end
    end

    assign win_valid = w_valid_reg;
    assign tag       = tag_reg;

endmodule

[design/v2wc_back.sv]
// ----------------------------------------------------------------------------
// v2wc_back: multiply-accumulate pipeline and output skid queue
// Multiplies the window by the kernel, sums in two stages, queues results.
// ----------------------------------------------------------------------------
module v2wc_back
    import v2wc_pkg::*;
#(
    parameter int KERNEL_SIZE = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              win_valid,
    input  logic signed [SAMPLE_BITS-1:0]     win [KERNEL_SIZE][KERNEL_SIZE],
    input  v2wc_tag_t                         tag,
    input  logic [63:0]                       krow [4],
    output logic                              advance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SUM_BITS-1:0]               out_sum,
    output v2wc_tag_t                         out_tag
);
    localparam int PB = SAMPLE_BITS + COEF_BITS;
    localparam int QD = 4;

    // Products, row sums, queue
    logic signed [PB-1:0]       prod_reg [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [SUM_BITS-1:0] rsum_reg [KERNEL_SIZE];
    logic signed [SUM_BITS-1:0] rsum_next [KERNEL_SIZE];
    logic signed [SUM_BITS-1:0] tot;
    logic [1:0]                 v_reg;
    v2wc_tag_t                  t0_reg, t1_reg;

    logic [SUM_BITS-1:0] q_sum [QD];
    v2wc_tag_t           q_tag [QD];
    logic [1:0]          wp_reg, rp_reg;
    logic [2:0]          cnt_reg;
    logic                push, pop;

    // Stall front when queue could not absorb in-flight results
    assign advance = (cnt_reg + 3'(v_reg[0]) + 3'(v_reg[1])) < 3'(QD);

    // Stage A: products
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    prod_reg[r][c] <= PB'(win[r][c] *
                        signed'(krow[r][16*c +: COEF_BITS]));
                end
            end
            t0_reg <= tag;
        end
    end

    // Stage B: row sums
    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            rsum_next[r] = '0;
            for (int c = 0; c < KERNEL_SIZE; c++) begin
                rsum_next[r] = rsum_next[r] + SUM_BITS'(prod_reg[r][c]);
            end
        end
        tot = '0;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            tot = tot + rsum_reg[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rsum_reg <= rsum_next;
            t1_reg   <= t0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (advance) begin
            v_reg <= {v_reg[0], win_valid};
        end
    end

    // Result queue
    assign push      = advance && v_reg[1];
    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != 3'd0;
    assign out_sum   = q_sum[rp_reg];
    assign out_tag   = q_tag[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_sum[wp_reg] <= tot;
            q_tag[wp_reg] <= t1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

[design/valid_2d_window_correlation_top.sv]
// Throughput: one sample per cycle; the front stalls when the results held in the
// four-deep queue plus those in the two multiply-add stages reach four.
// Reset: synchronous active-low aresetn clears position, window and queue; registers
// return to width 1024, height 1024, zero kernel. The line store is not cleared.
// ----------------------------------------------------------------------------
// valid_2d_window_correlation_top: streaming KxK valid-region correlation
// Configuration registers, front window builder and back MAC pipeline.
// ----------------------------------------------------------------------------
module valid_2d_window_correlation_top
    import v2wc_pkg::*;
#(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [15:0] sample
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [63:0]              m_tdata,   // [35:0] filtered, [51:36] out_row, [61:52] out_col
    output logic                     m_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [63:0]              cfg_data
);
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [63:0] krow_reg [4];
    logic        advance, win_valid;
    logic signed [SAMPLE_BITS-1:0] win [KERNEL_SIZE][KERNEL_SIZE];
    v2wc_tag_t   tag, out_tag;
    logic [SUM_BITS-1:0] out_sum;

    assign cfg_ready = 1'b1;
    assign s_tready  = advance;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1024;
            height_reg <= 16'd1024;
            for (int i = 0; i < 4; i++) krow_reg[i] <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg   <= cfg_data[10:0];
                REG_HEIGHT: height_reg  <= cfg_data[15:0];
                REG_KROW0:  krow_reg[0] <= cfg_data;
                REG_KROW1:  krow_reg[1] <= cfg_data;
                REG_KROW2:  krow_reg[2] <= cfg_data;
                REG_KROW3:  krow_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    v2wc_front #(
        .KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_sample(s_tdata),
        .advance(advance), .width(width_reg), .height(height_reg),
        .win_valid(win_valid), .win_reg(win), .tag(tag)
    );

    v2wc_back #(
        .KERNEL_SIZE(KERNEL_SIZE), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .win_valid(win_valid), .win(win), .tag(tag),
        .krow(krow_reg), .advance(advance), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_sum(out_sum), .out_tag(out_tag)
    );

    assign m_tdata = {2'b00, out_tag.col, out_tag.row, out_sum};
    assign m_tlast = out_tag.last;

endmodule

[sim/valid_2d_window_correlation_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// valid_2d_window_correlation_top_test: self-checking bench for the 3x3 block
// Streams whole frames of random and extreme samples under several image
// sizes and kernels, predicts every valid-region window sum with its row,
// column and frame-last mark, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module valid_2d_window_correlation_top_test;
    import v2wc_pkg::*;

    localparam int KSIZE          = 3;
    localparam int MAXW           = 1024;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PIPE_DRAIN     = 12;
    localparam int RANDOM_ITEMS   = 400;

    typedef struct {
        logic signed [SUM_BITS-1:0] sum;
        logic [ROW_BITS-1:0]        row;
        logic [COL_BITS-1:0]        col;
        logic                       last;
    } window_result_t;

    // Window sum predictor and in-order store of expected results
    class corr_scoreboard;
        logic signed [15:0] line_rows[KSIZE-1][MAXW];
        logic signed [15:0] win[KSIZE][KSIZE];
        int unsigned        col_pos;
        int unsigned        row_pos;
        logic [10:0]        width;
        logic [15:0]        height;
        logic [63:0]        krow[4];
        window_result_t     expected_q[$];
        int                 errors;
        int                 checked;

        function new();
            foreach (line_rows[r, c]) line_rows[r][c] = '0;
            foreach (win[r, c]) win[r][c] = '0;
            foreach (krow[r]) krow[r] = '0;
            col_pos = 0;
            row_pos = 0;
            width   = 11'd1024;
            height  = 16'd1024;
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] value);
            case (idx)
                REG_WIDTH:  width   = value[10:0];
                REG_HEIGHT: height  = value[15:0];
                REG_KROW0:  krow[0] = value;
                REG_KROW1:  krow[1] = value;
                REG_KROW2:  krow[2] = value;
                REG_KROW3:  krow[3] = value;
                default: ;
            endcase
        endfunction

        // Advance line stores and window by one sample; queue a result if valid
        function void note_sample(logic [15:0] raw);
            int unsigned        w;
            int unsigned        h;
            logic signed [15:0] newcol[KSIZE];
            logic signed [15:0] coef;
            bit                 row_end;
            bit                 frame_end;
            longint             acc;
            window_result_t     res;
            w = width;
            if (w == 0) w = 1;
            if (w > MAXW) w = MAXW;
            h = height;
            if (h == 0) h = 1;
            row_end   = col_pos >= w - 1;
            frame_end = row_end && row_pos >= h - 1;
            for (int r = 0; r < KSIZE - 1; r++) newcol[r] = line_rows[r][col_pos];
            for (int r = 0; r < KSIZE - 2; r++) line_rows[r][col_pos] = line_rows[r + 1][col_pos];
            line_rows[KSIZE - 2][col_pos] = raw;
            newcol[KSIZE - 1] = raw;
            for (int r = 0; r < KSIZE; r++) begin
                for (int c = 0; c < KSIZE - 1; c++) win[r][c] = win[r][c + 1];
                win[r][KSIZE - 1] = newcol[r];
            end
            if (row_pos >= KSIZE - 1 && col_pos >= KSIZE - 1) begin
                acc = 0;
                for (int r = 0; r < KSIZE; r++) begin
                    for (int c = 0; c < KSIZE; c++) begin
                        coef = krow[r][16*c +: 16];
                        acc += longint'(win[r][c]) * longint'(coef);
                    end
                end
                res.sum  = acc[SUM_BITS-1:0];
                res.row  = ROW_BITS'(row_pos - (KSIZE - 1));
                res.col  = COL_BITS'(col_pos - (KSIZE - 1));
                res.last = frame_end;
                expected_q.push_back(res);
            end
            if (row_end) begin
                col_pos = 0;
                row_pos = frame_end ? 0 : ((row_pos + 1) & 16'hffff);
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic [63:0] data, logic last);
            window_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result data=%h last=%b", data, last));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (data[35:0] !== e.sum)
                report($sformatf("filtered %0d, want %0d", $signed(data[35:0]), e.sum));
            if (data[51:36] !== e.row)
                report($sformatf("out_row %0d, want %0d", data[51:36], e.row));
            if (data[61:52] !== e.col)
                report($sformatf("out_col %0d, want %0d", data[61:52], e.col));
            if (last !== e.last)
                report($sformatf("frame_last %b, want %b (row %0d col %0d)",
                                 last, e.last, e.row, e.col));
        endtask
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [15:0]             s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [63:0]             m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [63:0]             cfg_data;

    corr_scoreboard sb = new();
    int  rx_hold   = 0;
    int  rx_stall  = 0;
    bit  rx_idle_en = 1'b0;
    bit  tx_idle_en = 1'b0;
    int  idle_cycles = 0;
    int  samples_sent = 0;
    int  frames_run   = 0;

    valid_2d_window_correlation_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive result-side ready: forced hold-off first, then random stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
            end
        end
    end

    // Check each result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata, m_tlast);
    end

    // Watchdog: end the run after too long without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Write one register; valid stays high for a following write
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
        @(negedge aclk);
    endtask

    // Wait until every expected result is in, then let the pipeline drain
    task automatic settle();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (PIPE_DRAIN) @(negedge aclk);
    endtask

    function automatic logic [63:0] make_kernel_row(int kmode);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (kmode == 1) begin
            for (int c = 0; c < 4; c++) begin
                case ($urandom_range(0, 3))
                    0: v[16*c +: 16] = 16'h8000;
                    1: v[16*c +: 16] = 16'h7fff;
                    2: v[16*c +: 16] = 16'hffff;
                    default: ;
                endcase
            end
        end
        return v;
    endfunction

    // Set geometry and kernel while idle
    task automatic configure(int w, int h, int kmode);
        settle();
        write_reg(REG_WIDTH, 64'(w));
        write_reg(REG_HEIGHT, 64'(h));
        write_reg(REG_KROW0, make_kernel_row(kmode));
        write_reg(REG_KROW1, make_kernel_row(kmode));
        write_reg(REG_KROW2, make_kernel_row(kmode));
        write_reg(REG_KROW3, make_kernel_row(kmode));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] make_sample(int smode);
        if (smode == 1) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'hffff;
                default: return 16'h0000;
            endcase
        end
        if (smode == 2) return 16'($signed($urandom_range(0, 15)) - 8);
        return 16'($urandom);
    endfunction

    // Offer one sample and hold it until accepted; called at a falling edge
    task automatic send_sample(logic [15:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(value);
        samples_sent++;
        @(negedge aclk);
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stream one whole frame of the current geometry
    task automatic stream_frame(int w, int h, int smode, bit pause_mid);
        int n;
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        if (h == 0) h = 1;
        n = w * h;
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) begin
                // hold the sender until every result so far is out
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(negedge aclk);
                @(negedge aclk);
            end
            send_sample(make_sample(smode));
        end
        s_tvalid <= 1'b0;
        frames_run++;
    endtask

    initial begin
        int w;
        int h;
        int phase;
        int start_count;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: smallest image with extreme kernel and samples
        configure(3, 3, 1);
        stream_frame(3, 3, 1, 1'b0);
        // Zero width and height act as one by one
        configure(0, 0, 0);
        stream_frame(1, 1, 0, 1'b0);
        // Image narrower than the kernel: samples consumed, no result
        configure(2, 4, 0);
        stream_frame(2, 4, 0, 1'b0);

        // Register extremes: oversized width clamps, tallest height then trimmed
        settle();
        write_reg(REG_WIDTH, 64'h7ff);
        write_reg(REG_HEIGHT, 64'hffff);
        write_reg(REG_HEIGHT, 64'd1);
        write_reg(REG_KROW0, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_KROW1, 64'h0);
        write_reg(REG_KROW2, make_kernel_row(0));
        write_reg(REG_KROW3, 64'hffff_ffff_ffff_ffff);
        cfg_valid <= 1'b0;
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        stream_frame(2047, 1, 0, 1'b0);

        // Random frames, mostly small
        start_count = samples_sent;
        phase = 0;
        while (samples_sent - start_count < RANDOM_ITEMS || phase <= 5) begin
            case ($urandom_range(0, 9))
                0: w = $urandom_range(1, 2);
                1: w = $urandom_range(13, 40);
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0: h = $urandom_range(1, 2);
                1: h = $urandom_range(9, 20);
                default: h = $urandom_range(3, 8);
            endcase
            // keep the total sample count near the budget
            while (h > 1 && w * h > RANDOM_ITEMS + 40 - (samples_sent - start_count)) h--;
            if (phase == 3) begin
                w = 12;
                h = 10;
            end
            configure(w, h, ($urandom_range(0, 3) == 0) ? 1 : 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            if (phase == 3) begin
                // long receiver hold-off while samples keep coming
                tx_idle_en = 1'b0;
                rx_hold = 300;
            end
            stream_frame(w, h, ($urandom_range(0, 4) == 0) ? 1 : 0, phase == 5);
            phase++;
        end

        // Drain and finish
        while (sb.pending() != 0) @(negedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
        while (sb.pending() != 0) begin
            sb.report("expected result never arrived");
            void'(sb.expected_q.pop_front());
        end
        $display("run covered %0d samples in %0d frames, %0d window results checked",
                 samples_sent, frames_run, sb.checked);
        $display("geometries from 0x0 to 1024 wide, extreme kernels, stalls on both sides");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
